/* rtl/tsmf_pkg.sv */
`default_nettype none
package tsmf_pkg;

    localparam int MAX_PEERS = 8;
    localparam int PEER_AW   = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CFG_IW    = 4;
    localparam int CFG_DW    = 48;

    localparam logic [7:0] UNKNOWN_NODE = 8'd255;

    localparam logic [1:0] PH_PROBE  = 2'd1;
    localparam logic [1:0] PH_REPORT = 2'd2;

    typedef enum logic [2:0] {
        ACT_CLEAR = 3'd0,
        ACT_LOAD  = 3'd1,
        ACT_SLOT  = 3'd2,
        ACT_CHECK = 3'd3,
        ACT_TAKE  = 3'd4,
        ACT_SEQ   = 3'd5
    } t_action;

    typedef enum logic [CFG_IW-1:0] {
        REG_OWN_NODE   = 4'd0,
        REG_HOST_NODE  = 4'd1,
        REG_AP_ADDRESS = 4'd2,
        REG_AP_KNOWN   = 4'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  entry_index;
        logic [7:0]  entry_node;
        logic [47:0] mac_address;
        logic [31:0] cycle_number;
        logic [7:0]  slot_number;
        logic [7:0]  sender_node;
        logic [7:0]  listener_node;
        logic [1:0]  phase;
        logic [31:0] seq_value;
    } t_in_item;

    typedef struct packed {
        logic        mac_allowed;
        logic        mac_scheduled;
        logic [7:0]  mac_source_node;
        logic        sample_taken;
        logic        probe_active;
        logic        clear_capture;
        logic        send_probe;
        logic        flush_report;
        logic [31:0] probe_seq;
        logic [31:0] current_cycle;
        logic [7:0]  current_slot;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  own_node;
        logic [7:0]  host_node;
        logic [47:0] ap_address;
        logic        ap_known;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  id;
        logic [47:0] mac;
    } t_peer_entry;

    typedef struct packed {
        logic busy;
        logic out_load;
    } t_eng_status;

endpackage
`default_nettype wire

/* rtl/tsmf_peer_ram.sv */
`default_nettype none
module tsmf_peer_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [tsmf_pkg::PEER_AW-1:0] i_waddr,
    input  wire tsmf_pkg::t_peer_entry      i_wdata,
    input  wire logic                       i_re,
    input  wire logic [tsmf_pkg::PEER_AW-1:0] i_raddr,
    output tsmf_pkg::t_peer_entry           o_rdata
);

    tsmf_pkg::t_peer_entry r_mem [tsmf_pkg::MAX_PEERS];
    tsmf_pkg::t_peer_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/tsmf_engine.sv */
`default_nettype none
module tsmf_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tsmf_pkg::t_cfg      i_cfg,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tsmf_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tsmf_pkg::t_out_item      o_out_data,
    output tsmf_pkg::t_eng_status    o_status
);

    tsmf_pkg::t_state r_state, n_state;

    logic                      r_probe_on,  n_probe_on;
    logic [31:0]               r_slot_cycle, n_slot_cycle;
    logic [7:0]                r_slot_index, n_slot_index;
    logic [7:0]                r_slot_sender, n_slot_sender;
    logic [7:0]                r_slot_listener, n_slot_listener;
    logic                      r_taken, n_taken;
    logic [31:0]               r_kept_cycle, n_kept_cycle;
    logic [7:0]                r_kept_slot, n_kept_slot;
    logic [31:0]               r_local_seq, n_local_seq;
    logic [31:0]               r_last_seq, n_last_seq;
    logic [tsmf_pkg::MAX_PEERS-1:0] r_valid, n_valid;

    logic [47:0]               r_mac;
    logic [tsmf_pkg::PEER_AW-1:0] r_cnt, r_ridx;
    logic                      r_rvld;
    logic                      r_fm, r_fs, r_sm;
    logic [7:0]                r_fid;

    logic                      r_out_valid;
    tsmf_pkg::t_out_item       r_out, n_out;

    logic                      accept, is_check, out_free;
    logic                      rd_en, last_rd, load_out;
    logic                      clr, sendp, flush;
    logic                      is_ap, allowed, sched;
    logic [7:0]                source;
    logic                      hit_mac, hit_id;
    logic                      we;
    tsmf_pkg::t_peer_entry     rdata, wdata;

    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && o_in_ready;
    assign is_check = (i_in_data.action == 3'(tsmf_pkg::ACT_CHECK));
    assign last_rd  = (r_cnt == tsmf_pkg::PEER_AW'(tsmf_pkg::MAX_PEERS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            tsmf_pkg::ST_IDLE: begin
                if (accept && is_check) n_state = tsmf_pkg::ST_SCAN;
            end
            tsmf_pkg::ST_SCAN: begin
                if (last_rd) n_state = tsmf_pkg::ST_WAIT;
            end
            tsmf_pkg::ST_WAIT: n_state = tsmf_pkg::ST_FIN;
            tsmf_pkg::ST_FIN:  n_state = tsmf_pkg::ST_IDLE;
            default:           n_state = tsmf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            tsmf_pkg::ST_IDLE: begin
                o_in_ready = out_free;
                load_out   = accept && !is_check;
            end
            tsmf_pkg::ST_SCAN: rd_en    = 1'b1;
            tsmf_pkg::ST_FIN:  load_out = 1'b1;
            default: ;
        endcase
    end

    // slot state and table writes
    always_comb begin
        n_probe_on      = r_probe_on;
        n_slot_cycle    = r_slot_cycle;
        n_slot_index    = r_slot_index;
        n_slot_sender   = r_slot_sender;
        n_slot_listener = r_slot_listener;
        n_taken         = r_taken;
        n_kept_cycle    = r_kept_cycle;
        n_kept_slot     = r_kept_slot;
        n_local_seq     = r_local_seq;
        n_last_seq      = r_last_seq;
        n_valid         = r_valid;
        clr             = 1'b0;
        sendp           = 1'b0;
        flush           = 1'b0;
        we              = 1'b0;
        if (accept) begin
            case (i_in_data.action)
                3'(tsmf_pkg::ACT_CLEAR): n_valid = '0;
                3'(tsmf_pkg::ACT_LOAD): begin
                    if (32'(i_in_data.entry_index) < 32'(tsmf_pkg::MAX_PEERS)) begin
                        we = 1'b1;
                        n_valid[tsmf_pkg::PEER_AW'(i_in_data.entry_index)] = 1'b1;
                    end
                end
                3'(tsmf_pkg::ACT_SLOT): begin
                    n_slot_cycle    = i_in_data.cycle_number;
                    n_slot_index    = i_in_data.slot_number;
                    n_slot_sender   = i_in_data.sender_node;
                    n_slot_listener = i_in_data.listener_node;
                    n_taken         = 1'b0;
                    n_probe_on      = 1'b0;
                    if (i_in_data.phase == tsmf_pkg::PH_PROBE) begin
                        n_probe_on = 1'b1;
                        clr = (i_in_data.slot_number == 8'd0);
                        if (i_in_data.sender_node == i_cfg.own_node) begin
                            n_local_seq = r_local_seq + 32'd1;
                            n_last_seq  = r_local_seq + 32'd1;
                            sendp       = 1'b1;
                        end
                    end else if (i_in_data.phase == tsmf_pkg::PH_REPORT) begin
                        flush = (i_in_data.sender_node == i_cfg.own_node);
                    end
                end
                3'(tsmf_pkg::ACT_TAKE): begin
                    n_kept_cycle = r_slot_cycle;
                    n_kept_slot  = r_slot_index;
                    n_taken      = 1'b1;
                end
                3'(tsmf_pkg::ACT_SEQ): n_last_seq = i_in_data.seq_value;
                default: ;
            endcase
        end
    end

    assign wdata.id  = i_in_data.entry_node;
    assign wdata.mac = i_in_data.mac_address;

    tsmf_peer_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (tsmf_pkg::PEER_AW'(i_in_data.entry_index)),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_cnt),
        .o_rdata (rdata)
    );

    assign hit_mac = r_valid[r_ridx] && (rdata.mac == r_mac);
    assign hit_id  = r_valid[r_ridx] && (rdata.id == r_slot_sender);

    // frame verdict from the finished scan
    always_comb begin
        is_ap   = i_cfg.ap_known && (r_mac == i_cfg.ap_address);
        allowed = 1'b0;
        source  = tsmf_pkg::UNKNOWN_NODE;
        sched   = 1'b0;
        if (r_state == tsmf_pkg::ST_FIN) begin
            allowed = is_ap || r_fm;
            if (is_ap) begin
                source = i_cfg.host_node;
            end else if (r_fm) begin
                source = r_fid;
            end
            if (r_probe_on) begin
                if (r_slot_sender == i_cfg.host_node) begin
                    sched = ((r_slot_listener == 8'd0) || (r_slot_listener == i_cfg.own_node))
                            && is_ap;
                end else begin
                    sched = r_fs && r_sm;
                end
            end
        end
    end

    always_comb begin
        n_out.mac_allowed     = allowed;
        n_out.mac_scheduled   = sched;
        n_out.mac_source_node = source;
        n_out.sample_taken    = n_taken && (n_kept_cycle == n_slot_cycle)
                                && (n_kept_slot == n_slot_index);
        n_out.probe_active    = n_probe_on;
        n_out.clear_capture   = clr;
        n_out.send_probe      = sendp;
        n_out.flush_report    = flush;
        n_out.probe_seq       = n_last_seq;
        n_out.current_cycle   = n_slot_cycle;
        n_out.current_slot    = n_slot_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= tsmf_pkg::ST_IDLE;
            r_probe_on      <= 1'b0;
            r_slot_cycle    <= '0;
            r_slot_index    <= '0;
            r_slot_sender   <= '0;
            r_slot_listener <= '0;
            r_taken         <= 1'b0;
            r_kept_cycle    <= '0;
            r_kept_slot     <= '0;
            r_local_seq     <= '0;
            r_last_seq      <= '0;
            r_valid         <= '0;
            r_cnt           <= '0;
            r_rvld          <= 1'b0;
            r_fm            <= 1'b0;
            r_fs            <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_probe_on      <= n_probe_on;
            r_slot_cycle    <= n_slot_cycle;
            r_slot_index    <= n_slot_index;
            r_slot_sender   <= n_slot_sender;
            r_slot_listener <= n_slot_listener;
            r_taken         <= n_taken;
            r_kept_cycle    <= n_kept_cycle;
            r_kept_slot     <= n_kept_slot;
            r_local_seq     <= n_local_seq;
            r_last_seq      <= n_last_seq;
            r_valid         <= n_valid;
            r_rvld          <= rd_en;
            if (accept) begin
                r_cnt <= '0;
                r_fm  <= 1'b0;
                r_fs  <= 1'b0;
            end else begin
                if (rd_en && !last_rd) r_cnt <= r_cnt + 1'b1;
                if (r_rvld && hit_mac) r_fm <= 1'b1;
                if (r_rvld && hit_id)  r_fs <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_mac <= i_in_data.mac_address;
        r_ridx <= r_cnt;
        if (r_rvld && hit_mac && !r_fm) r_fid <= rdata.id;
        if (r_rvld && hit_id && !r_fs)  r_sm  <= (rdata.mac == r_mac);
        if (load_out) r_out <= n_out;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_status.busy     = (r_state != tsmf_pkg::ST_IDLE);
    assign o_status.out_load = load_out;

endmodule
`default_nettype wire

/* rtl/tdma_slot_mac_filter_unit.sv */
`default_nettype none
// Time-slotted frame filter. One beat in, one beat out. A check-frame beat
// scans the peer table through its single read port, one entry per cycle,
// and returns its result after the SCAN, WAIT and FIN states; all other
// actions return their result in the cycle after acceptance.
// A new beat is taken once the previous one has finished and the output
// register is free or being drained. Config writes are taken every cycle.
module tdma_slot_mac_filter_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tsmf_pkg::CFG_IW-1:0]       i_cfg_index,
    input  wire logic [tsmf_pkg::CFG_DW-1:0]       i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tsmf_pkg::t_in_item                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tsmf_pkg::t_out_item                    o_out_data
);

    tsmf_pkg::t_cfg        r_cfg;
    tsmf_pkg::t_eng_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_node   <= 8'd1;
            r_cfg.host_node  <= 8'd0;
            r_cfg.ap_address <= '0;
            r_cfg.ap_known   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tsmf_pkg::REG_OWN_NODE:   r_cfg.own_node   <= i_cfg_data[7:0];
                tsmf_pkg::REG_HOST_NODE:  r_cfg.host_node  <= i_cfg_data[7:0];
                tsmf_pkg::REG_AP_ADDRESS: r_cfg.ap_address <= i_cfg_data[47:0];
                tsmf_pkg::REG_AP_KNOWN:   r_cfg.ap_known   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tsmf_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_status    (status)
    );

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.busy |-> !o_in_ready)
        else $error("input ready while scan in progress");

    a_load_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.out_load |=> o_out_valid)
        else $error("result load did not raise output valid");

    a_clear_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clear_capture |-> o_out_data.probe_active)
        else $error("capture clear outside probe slot");

    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.send_probe && o_out_data.flush_report))
        else $error("probe and flush pulsed together");

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;

    localparam logic [2:0] ACT_RSVD_A = 3'd6;
    localparam logic [2:0] ACT_RSVD_B = 3'd7;
    localparam logic [1:0] PH_OTHER   = 2'd0;
    localparam logic [1:0] PH_SPARE   = 2'd3;

    localparam int SETTLE_CYCLES   = 16;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 6;
    localparam int BEATS_PER_PHASE = 180;
    localparam int POOL_SIZE       = 6;

    localparam logic [47:0] MAC_A    = 48'h02_11_22_33_44_55;
    localparam logic [47:0] MAC_B    = 48'h02_AA_BB_CC_DD_EE;
    localparam logic [47:0] MAC_C    = 48'hA5_5A_0F_F0_C3_3C;
    localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [tsmf_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [tsmf_pkg::CFG_DW-1:0] cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    tsmf_pkg::t_in_item          in_beat   = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    tsmf_pkg::t_out_item         out_beat;

    bit                  gaps_on      = 1'b1;
    int                  mismatch_cnt = 0;
    tsmf_pkg::t_out_item pending_results[$];

    // filter model: configuration
    logic [7:0]  own_id  = 8'd1;
    logic [7:0]  host_id = 8'd0;
    logic [47:0] ap_addr = '0;
    logic        ap_ok   = 1'b0;

    // filter model: peer table and slot state
    logic [7:0]  tbl_id  [tsmf_pkg::MAX_PEERS];
    logic [47:0] tbl_mac [tsmf_pkg::MAX_PEERS];
    logic        tbl_ok  [tsmf_pkg::MAX_PEERS];
    logic        probe_on      = 1'b0;
    logic [31:0] slot_cycle    = '0;
    logic [7:0]  slot_index    = '0;
    logic [7:0]  slot_sender   = '0;
    logic [7:0]  slot_listener = '0;
    logic        taken         = 1'b0;
    logic [31:0] kept_cycle    = '0;
    logic [7:0]  kept_slot     = '0;
    logic [31:0] local_seq     = '0;
    logic [31:0] last_seq      = '0;

    logic [7:0]  pool_node [POOL_SIZE];
    logic [47:0] pool_mac  [POOL_SIZE];

    tdma_slot_mac_filter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic tsmf_pkg::t_out_item predict_filter_result(
        input tsmf_pkg::t_in_item it);
        tsmf_pkg::t_out_item r;
        bit                  found;
        r = '0;
        r.mac_source_node = tsmf_pkg::UNKNOWN_NODE;
        case (it.action)
            tsmf_pkg::ACT_CLEAR: begin
                for (int k = 0; k < tsmf_pkg::MAX_PEERS; k++) begin
                    tbl_id[k]  = '0;
                    tbl_mac[k] = '0;
                    tbl_ok[k]  = 1'b0;
                end
            end
            tsmf_pkg::ACT_LOAD: begin
                if (it.entry_index < tsmf_pkg::MAX_PEERS) begin
                    tbl_id[it.entry_index]  = it.entry_node;
                    tbl_mac[it.entry_index] = it.mac_address;
                    tbl_ok[it.entry_index]  = 1'b1;
                end
            end
            tsmf_pkg::ACT_SLOT: begin
                slot_cycle    = it.cycle_number;
                slot_index    = it.slot_number;
                slot_sender   = it.sender_node;
                slot_listener = it.listener_node;
                taken         = 1'b0;
                probe_on      = (it.phase == tsmf_pkg::PH_PROBE);
                r.clear_capture = (it.phase == tsmf_pkg::PH_PROBE) && (it.slot_number == 8'd0);
                if (it.phase == tsmf_pkg::PH_PROBE && it.sender_node == own_id) begin
                    local_seq    = local_seq + 32'd1;
                    last_seq     = local_seq;
                    r.send_probe = 1'b1;
                end
                if (it.phase == tsmf_pkg::PH_REPORT && it.sender_node == own_id)
                    r.flush_report = 1'b1;
            end
            tsmf_pkg::ACT_CHECK: begin
                if (ap_ok && it.mac_address == ap_addr) begin
                    r.mac_allowed     = 1'b1;
                    r.mac_source_node = host_id;
                end else begin
                    found = 1'b0;
                    for (int k = 0; k < tsmf_pkg::MAX_PEERS; k++) begin
                        if (!found && tbl_ok[k] && tbl_mac[k] == it.mac_address) begin
                            found             = 1'b1;
                            r.mac_allowed     = 1'b1;
                            r.mac_source_node = tbl_id[k];
                        end
                    end
                end
                if (probe_on) begin
                    if (slot_sender == host_id) begin
                        r.mac_scheduled = (slot_listener == 8'd0 || slot_listener == own_id)
                                          && ap_ok && it.mac_address == ap_addr;
                    end else begin
                        found = 1'b0;
                        for (int k = 0; k < tsmf_pkg::MAX_PEERS; k++) begin
                            if (!found && tbl_ok[k] && tbl_id[k] == slot_sender) begin
                                found           = 1'b1;
                                r.mac_scheduled = (tbl_mac[k] == it.mac_address);
                            end
                        end
                    end
                end
            end
            tsmf_pkg::ACT_TAKE: begin
                kept_cycle = slot_cycle;
                kept_slot  = slot_index;
                taken      = 1'b1;
            end
            tsmf_pkg::ACT_SEQ: begin
                last_seq = it.seq_value;
            end
            default: begin
            end
        endcase
        r.sample_taken  = taken && kept_cycle == slot_cycle && kept_slot == slot_index;
        r.probe_active  = probe_on;
        r.probe_seq     = last_seq;
        r.current_cycle = slot_cycle;
        r.current_slot  = slot_index;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk) begin : result_check
        tsmf_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expected result pending");
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("mac_allowed", 32'(want.mac_allowed),
                            32'(out_beat.mac_allowed));
                check_field("mac_scheduled", 32'(want.mac_scheduled),
                            32'(out_beat.mac_scheduled));
                check_field("mac_source_node", 32'(want.mac_source_node),
                            32'(out_beat.mac_source_node));
                check_field("sample_taken", 32'(want.sample_taken),
                            32'(out_beat.sample_taken));
                check_field("probe_active", 32'(want.probe_active),
                            32'(out_beat.probe_active));
                check_field("clear_capture", 32'(want.clear_capture),
                            32'(out_beat.clear_capture));
                check_field("send_probe", 32'(want.send_probe),
                            32'(out_beat.send_probe));
                check_field("flush_report", 32'(want.flush_report),
                            32'(out_beat.flush_report));
                check_field("probe_seq", want.probe_seq, out_beat.probe_seq);
                check_field("current_cycle", want.current_cycle, out_beat.current_cycle);
                check_field("current_slot", 32'(want.current_slot),
                            32'(out_beat.current_slot));
            end
        end
        out_ready <= !gaps_on || ($urandom_range(99) >= 26);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic logic [47:0] random_mac();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic tsmf_pkg::t_in_item random_fields();
        logic [159:0] bits;
        for (int k = 0; k < 5; k++)
            bits[k*32 +: 32] = $urandom;
        return bits[$bits(tsmf_pkg::t_in_item)-1:0];
    endfunction

    task automatic send_beat(input tsmf_pkg::t_in_item item);
        if (gaps_on) begin
            while ($urandom_range(99) < 26) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_beat  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_filter_result(item));
    endtask

    task automatic send_op(input logic [2:0] act, input logic [31:0] seq);
        tsmf_pkg::t_in_item b;
        b = random_fields();
        b.action    = act;
        b.seq_value = seq;
        send_beat(b);
    endtask

    task automatic send_load(input logic [2:0] idx, input logic [7:0] node,
                             input logic [47:0] mac);
        tsmf_pkg::t_in_item b;
        b = random_fields();
        b.action      = tsmf_pkg::ACT_LOAD;
        b.entry_index = idx;
        b.entry_node  = node;
        b.mac_address = mac;
        send_beat(b);
    endtask

    task automatic send_slot(input logic [31:0] cyc, input logic [7:0] slot,
                             input logic [7:0] snd, input logic [7:0] lis,
                             input logic [1:0] ph);
        tsmf_pkg::t_in_item b;
        b = random_fields();
        b.action        = tsmf_pkg::ACT_SLOT;
        b.cycle_number  = cyc;
        b.slot_number   = slot;
        b.sender_node   = snd;
        b.listener_node = lis;
        b.phase         = ph;
        send_beat(b);
    endtask

    task automatic send_check(input logic [47:0] mac);
        tsmf_pkg::t_in_item b;
        b = random_fields();
        b.action      = tsmf_pkg::ACT_CHECK;
        b.mac_address = mac;
        send_beat(b);
    endtask

    // drop valid and wait until every result is back and the block is quiet
    task automatic settle_filter();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input tsmf_pkg::t_reg_index idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tsmf_pkg::REG_OWN_NODE:   own_id  = val[7:0];
            tsmf_pkg::REG_HOST_NODE:  host_id = val[7:0];
            tsmf_pkg::REG_AP_ADDRESS: ap_addr = val;
            tsmf_pkg::REG_AP_KNOWN:   ap_ok   = val[0];
            default: begin
            end
        endcase
    endtask

    task automatic program_filter(input logic [7:0] own, input logic [7:0] host,
                                  input logic [47:0] ap, input logic known);
        settle_filter();
        write_reg(tsmf_pkg::REG_OWN_NODE, {40'd0, own});
        write_reg(tsmf_pkg::REG_HOST_NODE, {40'd0, host});
        write_reg(tsmf_pkg::REG_AP_ADDRESS, ap);
        write_reg(tsmf_pkg::REG_AP_KNOWN, {47'd0, known});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_check(48'd0);
        send_op(tsmf_pkg::ACT_TAKE, $urandom);
    endtask

    task automatic test_peer_table();
        send_op(tsmf_pkg::ACT_CLEAR, $urandom);
        send_load(3'd0, 8'd5, MAC_A);
        send_load(3'd3, 8'd9, MAC_A);
        send_load(3'd7, 8'd255, MAC_ONES);
        send_load(3'd2, 8'd0, 48'd0);
        send_check(MAC_A);
        send_check(MAC_ONES);
        send_check(48'd0);
        send_check(MAC_B);
    endtask

    task automatic test_slot_events();
        program_filter(8'd5, 8'd200, MAC_C, 1'b1);
        send_slot(32'hFFFF_FFFF, 8'd0, 8'd9, 8'd0, tsmf_pkg::PH_PROBE);
        send_check(MAC_A);
        send_op(tsmf_pkg::ACT_TAKE, $urandom);
        send_slot(32'd7, 8'd255, 8'd5, 8'd255, tsmf_pkg::PH_PROBE);
        send_op(tsmf_pkg::ACT_SEQ, 32'hFFFF_FFFF);
        send_slot(32'd7, 8'd254, 8'd5, 8'd0, tsmf_pkg::PH_REPORT);
        send_slot(32'd8, 8'd0, 8'd5, 8'd0, PH_SPARE);
        send_slot(32'd8, 8'd1, 8'd5, 8'd0, PH_OTHER);
        send_slot(32'd9, 8'd1, 8'd200, 8'd0, tsmf_pkg::PH_PROBE);
        send_check(MAC_C);
        send_slot(32'd9, 8'd2, 8'd200, 8'd7, tsmf_pkg::PH_PROBE);
        send_check(MAC_C);
        send_slot(32'd9, 8'd3, 8'd200, 8'd5, tsmf_pkg::PH_PROBE);
        send_check(MAC_C);
        send_op(ACT_RSVD_A, 32'hFFFF_FFFF);
        send_op(ACT_RSVD_B, 32'd0);
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          n;
        bit          drained;
        logic [7:0]  lis;
        logic [1:0]  ph;
        drained = 1'b0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: program_filter(8'd0, 8'd255, 48'd0, 1'b1);
                1: program_filter(8'd255, 8'd0, MAC_ONES, 1'b0);
                2: begin
                    n = $urandom_range(0, 255);
                    program_filter(n[7:0], n[7:0], random_mac(), 1'b1);
                end
                default: program_filter(8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)),
                                        random_mac(), 1'($urandom_range(0, 1)));
            endcase
            gaps_on = (p != 2);
            pool_node[0] = own_id;
            pool_node[1] = host_id;
            pool_mac[0]  = ap_addr;
            pool_mac[1]  = (p == 1) ? MAC_ONES : random_mac();
            for (int k = 2; k < POOL_SIZE; k++) begin
                pool_node[k] = 8'($urandom_range(0, 255));
                pool_mac[k]  = random_mac();
            end
            sent = 0;
            while (sent < BEATS_PER_PHASE) begin
                if ($urandom_range(99) < 85) begin
                    send_op(tsmf_pkg::ACT_CLEAR, $urandom);
                    n = $urandom_range(1, tsmf_pkg::MAX_PEERS);
                    repeat (n) send_load(3'($urandom_range(0, 7)),
                                         pool_node[$urandom_range(0, POOL_SIZE-1)],
                                         pool_mac[$urandom_range(0, POOL_SIZE-1)]);
                    sent += n + 1;
                    n = $urandom_range(4, 16);
                    repeat (n) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: begin
                                case ($urandom_range(0, 3))
                                    0: lis = 8'd0;
                                    1: lis = own_id;
                                    2: lis = pool_node[$urandom_range(0, POOL_SIZE-1)];
                                    default: lis = 8'($urandom_range(0, 255));
                                endcase
                                ph = ($urandom_range(0, 1) != 0) ? tsmf_pkg::PH_PROBE
                                                                 : 2'($urandom_range(0, 3));
                                send_slot($urandom,
                                          ($urandom_range(0, 3) == 0)
                                              ? 8'd0
                                              : 8'($urandom_range(0, 255)),
                                          ($urandom_range(0, 4) != 0)
                                              ? pool_node[$urandom_range(0, POOL_SIZE-1)]
                                              : 8'($urandom_range(0, 255)),
                                          lis, ph);
                            end
                            3, 4, 5, 6: begin
                                send_check(($urandom_range(0, 3) == 0)
                                           ? random_mac()
                                           : pool_mac[$urandom_range(0, POOL_SIZE-1)]);
                            end
                            7: send_op(tsmf_pkg::ACT_TAKE, $urandom);
                            default: send_op(tsmf_pkg::ACT_SEQ, $urandom);
                        endcase
                    end
                    sent += n;
                end else begin
                    send_beat(random_fields());
                    sent++;
                end
                if (p == 3 && !drained && sent > BEATS_PER_PHASE / 2) begin
                    settle_filter();
                    drained = 1'b1;
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        for (int k = 0; k < tsmf_pkg::MAX_PEERS; k++) begin
            tbl_id[k]  = '0;
            tbl_mac[k] = '0;
            tbl_ok[k]  = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_peer_table();
        test_slot_events();
        test_random_traffic();
        settle_filter();
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
